@@ rtl/bftr_pkg.sv @@
package bftr_pkg;

   // Glyph and font sheet geometry.
   localparam int GLYPH_W     = 6;
   localparam int GLYPH_H     = 13;
   localparam int SHEET_W     = 192;
   localparam int SHEET_H     = 52;
   localparam int SHEET_COLS  = 32;
   localparam int SHEET_SIZE  = SHEET_W * SHEET_H;
   localparam int SHEET_WORDS = SHEET_H * SHEET_COLS;

   localparam int CX_W    = $clog2(SHEET_COLS);
   localparam int RY_W    = $clog2(SHEET_H);
   localparam int ADDR_W  = CX_W + RY_W;
   localparam int CELL_W  = 7;
   localparam int ROW_W   = $clog2(GLYPH_H);
   localparam int COORD_W = 13;
   localparam int OFF_W   = 24;

   // Request and response field widths.
   localparam int IDX_W   = 14;
   localparam int BYTE_W  = 8;
   localparam int COLOR_W = 24;
   localparam int WORD_W  = 32;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_X     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_Y     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXT_COLOR   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_OPAQUE       = 3'd5;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_DRAW = 1'b1;

   localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'd10;
   localparam logic [BYTE_W-1:0] CHAR_DOLLAR  = 8'd36;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'd65;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'd90;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'd97;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'd122;
   localparam logic [BYTE_W-1:0] CHAR_DIGIT_0 = 8'd48;
   localparam logic [BYTE_W-1:0] CHAR_DIGIT_9 = 8'd57;

   localparam logic [CELL_W-1:0] CELL_LOWER  = 7'd32;
   localparam logic [CELL_W-1:0] CELL_DIGIT  = 7'd64;
   localparam logic [CELL_W-1:0] CELL_DOLLAR = 7'd75;
   localparam logic [CELL_W-1:0] CELL_BLANK  = 7'd78;

   typedef struct packed {
      logic capture;
      logic prep;
      logic setup;
      logic row_load;
      logic row_last;
      logic sheet_write;
   } bftr_cmd_type;

   typedef struct packed {
      logic newline;
   } bftr_sts_type;

   // Maps a character byte to its cell on the font sheet.
   function automatic logic [CELL_W-1:0] glyph_cell(input logic [BYTE_W-1:0] code);
      logic [CELL_W-1:0] cell_no;
      cell_no = CELL_BLANK;
      if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z) begin
         cell_no = CELL_W'(code - CHAR_UPPER_A);
      end else if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) begin
         cell_no = CELL_W'(code - CHAR_LOWER_A) + CELL_LOWER;
      end else if (code >= CHAR_DIGIT_0 && code <= CHAR_DIGIT_9) begin
         cell_no = CELL_W'(code - CHAR_DIGIT_0) + CELL_DIGIT;
      end else if (code == CHAR_DOLLAR) begin
         cell_no = CELL_DOLLAR;
      end else begin
         case (code)
            8'd33:   cell_no = 7'd96;
            8'd63:   cell_no = 7'd97;
            8'd35:   cell_no = 7'd98;
            8'd38:   cell_no = 7'd99;
            8'd95:   cell_no = 7'd100;
            8'd37:   cell_no = 7'd101;
            8'd39:   cell_no = 7'd102;
            8'd44:   cell_no = 7'd103;
            8'd46:   cell_no = 7'd104;
            8'd59:   cell_no = 7'd105;
            8'd58:   cell_no = 7'd106;
            8'd94:   cell_no = 7'd107;
            8'd124:  cell_no = 7'd108;
            8'd96:   cell_no = 7'd111;
            8'd126:  cell_no = 7'd113;
            8'd61:   cell_no = 7'd114;
            8'd60:   cell_no = 7'd115;
            8'd62:   cell_no = 7'd116;
            8'd43:   cell_no = 7'd117;
            8'd45:   cell_no = 7'd118;
            8'd42:   cell_no = 7'd119;
            8'd47:   cell_no = 7'd120;
            8'd92:   cell_no = 7'd121;
            8'd40:   cell_no = 7'd122;
            8'd41:   cell_no = 7'd123;
            8'd123:  cell_no = 7'd124;
            8'd125:  cell_no = 7'd125;
            8'd91:   cell_no = 7'd126;
            8'd93:   cell_no = 7'd127;
            default: cell_no = CELL_BLANK;
         endcase
      end
      return cell_no;
   endfunction

endpackage

@@ rtl/bftr_if.sv @@
interface bftr_req_if;
   import bftr_pkg::*;

   logic              valid;
   logic              ready;
   logic              func;
   logic [IDX_W-1:0]  sheet_index;
   logic [BYTE_W-1:0] sheet_value;
   logic [BYTE_W-1:0] char_code;
   logic              start_of_text;

   modport source (output valid, func, sheet_index, sheet_value, char_code, start_of_text,
                   input ready);
   modport sink (input valid, func, sheet_index, sheet_value, char_code, start_of_text,
                 output ready);
endinterface

interface bftr_rsp_if;
   import bftr_pkg::*;

   logic               valid;
   logic               ready;
   logic [OFF_W-1:0]   offset_0;
   logic [OFF_W-1:0]   offset_1;
   logic [OFF_W-1:0]   offset_2;
   logic [OFF_W-1:0]   offset_3;
   logic [OFF_W-1:0]   offset_4;
   logic [OFF_W-1:0]   offset_5;
   logic [5:0]         write_mask;
   logic [5:0]         ink_mask;
   logic [WORD_W-1:0]  ink_word;
   logic               last_row;

   modport source (output valid, offset_0, offset_1, offset_2, offset_3, offset_4, offset_5,
                   write_mask, ink_mask, ink_word, last_row, input ready);
   modport sink (input valid, offset_0, offset_1, offset_2, offset_3, offset_4, offset_5,
                 write_mask, ink_mask, ink_word, last_row, output ready);
endinterface

interface bftr_csr_if;
   import bftr_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/bftr_ctrl.sv @@
module bftr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_func,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  bftr_pkg::bftr_sts_type sts,
   output bftr_pkg::bftr_cmd_type cmd
);
   import bftr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LD_DIV,
      ST_LD_SPLIT,
      ST_LD_WRITE,
      ST_PREP,
      ST_SETUP,
      ST_ROWS
   } state_type;

   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_H - 1);

   state_type        state_ff;
   logic             req_ready_ff;
   logic             rsp_valid_ff;
   logic [ROW_W-1:0] row_ff;
   logic             accept;
   logic             load;

   assign accept = (state_ff == ST_IDLE) && req_valid && req_ready_ff;
   // While rows are drawn, a row is loaded whenever the output register is empty or being emptied.
   assign load   = (state_ff == ST_ROWS) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      cmd             = '0;
      cmd.capture     = accept;
      cmd.prep        = (state_ff == ST_PREP);
      cmd.setup       = (state_ff == ST_SETUP);
      cmd.row_load    = load;
      cmd.row_last    = (row_ff == LAST_ROW);
      cmd.sheet_write = (state_ff == ST_LD_WRITE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
         row_ff       <= '0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  req_ready_ff <= 1'b0;
                  state_ff     <= (req_func == FUNC_DRAW) ? ST_PREP : ST_LD_DIV;
               end
            end
            ST_LD_DIV: begin
               state_ff <= ST_LD_SPLIT;
            end
            ST_LD_SPLIT: begin
               state_ff <= ST_LD_WRITE;
            end
            ST_LD_WRITE: begin
               state_ff     <= ST_IDLE;
               req_ready_ff <= 1'b1;
            end
            ST_PREP: begin
               if (sts.newline) begin
                  state_ff     <= ST_IDLE;
                  req_ready_ff <= 1'b1;
               end else begin
                  state_ff <= ST_SETUP;
               end
            end
            ST_SETUP: begin
               row_ff   <= '0;
               state_ff <= ST_ROWS;
            end
            ST_ROWS: begin
               if (load) begin
                  row_ff <= row_ff + 1'b1;
                  if (row_ff == LAST_ROW) begin
                     state_ff     <= ST_IDLE;
                     req_ready_ff <= 1'b1;
                  end
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_ready_ff <= 1'b1;
            end
         endcase
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/bftr_dp.sv @@
module bftr_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bftr_pkg::bftr_cmd_type               cmd,
   output bftr_pkg::bftr_sts_type               sts,
   input  logic [bftr_pkg::IDX_W-1:0]           req_sheet_index,
   input  logic [bftr_pkg::BYTE_W-1:0]          req_sheet_value,
   input  logic [bftr_pkg::BYTE_W-1:0]          req_char_code,
   input  logic                                 req_start_of_text,
   input  logic                                 csr_write,
   input  logic [bftr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bftr_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic [bftr_pkg::OFF_W-1:0]           offset_0,
   output logic [bftr_pkg::OFF_W-1:0]           offset_1,
   output logic [bftr_pkg::OFF_W-1:0]           offset_2,
   output logic [bftr_pkg::OFF_W-1:0]           offset_3,
   output logic [bftr_pkg::OFF_W-1:0]           offset_4,
   output logic [bftr_pkg::OFF_W-1:0]           offset_5,
   output logic [5:0]                           write_mask,
   output logic [5:0]                           ink_mask,
   output logic [bftr_pkg::WORD_W-1:0]          ink_word,
   output logic                                 last_row
);
   import bftr_pkg::*;

   // Division by three through the reciprocal 171/512, exact for operands below 256.
   localparam int DIV3_RECIP = 171;
   localparam int DIV3_SHIFT = 9;
   localparam int POS_W      = 18;

   function automatic logic [COORD_W-1:0] clamp_hi(input logic signed [POS_W-1:0] v,
                                                   input logic [COORD_W-1:0] hi);
      logic [COORD_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > $signed({{(POS_W-COORD_W){1'b0}}, hi})) begin
         r = hi;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

   // Configuration registers.
   logic signed [11:0]  origin_x_ff;
   logic signed [11:0]  origin_y_ff;
   logic [COORD_W-1:0]  frame_width_ff;
   logic [COORD_W-1:0]  frame_height_ff;
   logic [COLOR_W-1:0]  text_color_ff;
   logic                opaque_ff;

   // Captured request.
   logic [IDX_W-1:0]    idx_ff;
   logic                ink_bit_ff;
   logic [BYTE_W-1:0]   code_ff;
   logic                sot_ff;

   // Sheet load address split.
   logic [15:0]         prod_y;
   logic [6:0]          sheet_y_ff;
   logic [7:0]          sheet_x_ff;
   logic [14:0]         prod_cx;
   logic [CX_W-1:0]     wr_cx;
   logic [2:0]          wr_lane;
   logic [ADDR_W-1:0]   wr_addr;
   logic                wr_in_range;

   // Pen and glyph geometry.
   logic [15:0]         pen_x_ff;
   logic [15:0]         pen_y_ff;
   logic [15:0]         eff_x;
   logic [15:0]         eff_y;
   logic [16:0]         pen_y_nl;
   logic [16:0]         pen_x_adv;
   logic [CELL_W-1:0]   glyph_no;
   logic [CX_W-1:0]     cx_ff;
   logic [RY_W-1:0]     ry_ff;
   logic signed [POS_W-1:0] px_raw_ff;
   logic signed [POS_W-1:0] py_raw_ff;
   logic [COORD_W-1:0]  fw_eff;
   logic [COORD_W-1:0]  fh_eff;
   logic [COORD_W-1:0]  py_c;
   logic [COORD_W-1:0]  py_c_ff;
   logic [COORD_W-1:0]  py_c_next;
   logic [2*COORD_W-1:0] base_prod;
   logic [OFF_W-1:0]    base_ff;
   logic [COORD_W-1:0]  px_ff [GLYPH_W];

   // Font sheet: one word of six pixels for each glyph row of each cell column.
   logic [GLYPH_W-1:0]  sheet_mem [SHEET_WORDS];
   logic [GLYPH_W-1:0]  sheet_q_ff;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;

   // Output register.
   logic [OFF_W-1:0]    offset_ff [GLYPH_W];
   logic [5:0]          write_mask_ff;
   logic [5:0]          ink_mask_ff;
   logic [WORD_W-1:0]   ink_word_ff;
   logic                last_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff     <= '0;
         origin_y_ff     <= '0;
         frame_width_ff  <= 13'd640;
         frame_height_ff <= 13'd480;
         text_color_ff   <= 24'hFFFFFF;
         opaque_ff       <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ORIGIN_X:     origin_x_ff     <= csr_data[11:0];
            CSR_ORIGIN_Y:     origin_y_ff     <= csr_data[11:0];
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[COORD_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[COORD_W-1:0];
            CSR_TEXT_COLOR:   text_color_ff   <= csr_data[COLOR_W-1:0];
            CSR_OPAQUE:       opaque_ff       <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff     <= req_sheet_index;
         ink_bit_ff <= (req_sheet_value == '0);
         code_ff    <= req_char_code;
         sot_ff     <= req_start_of_text;
      end
   end

   // Row of the sheet is index / 192, taken as (index / 64) / 3; the column follows.
   assign prod_y = 16'(idx_ff[IDX_W-1:6]) * 16'(DIV3_RECIP);

   always_ff @(posedge clock) begin
      sheet_y_ff <= prod_y[15:DIV3_SHIFT];
      sheet_x_ff <= 8'(idx_ff - (IDX_W'(sheet_y_ff) << 7) - (IDX_W'(sheet_y_ff) << 6));
   end

   // Cell column is x / 6, taken as (x / 2) / 3; the lane is what remains.
   assign prod_cx     = 15'(sheet_x_ff[7:1]) * 15'(DIV3_RECIP);
   assign wr_cx       = prod_cx[DIV3_SHIFT+CX_W-1:DIV3_SHIFT];
   assign wr_lane     = 3'(sheet_x_ff - (8'(wr_cx) << 2) - (8'(wr_cx) << 1));
   assign wr_addr     = {sheet_y_ff[RY_W-1:0], wr_cx};
   assign wr_in_range = (idx_ff < IDX_W'(SHEET_SIZE));

   assign glyph_no  = glyph_cell(code_ff);
   assign eff_x     = sot_ff ? '0 : pen_x_ff;
   assign eff_y     = sot_ff ? '0 : pen_y_ff;
   assign pen_y_nl  = 17'(eff_y) + 17'(GLYPH_H);
   assign pen_x_adv = 17'(pen_x_ff) + 17'(GLYPH_W);
   assign sts.newline = (code_ff == CHAR_NEWLINE);

   assign fw_eff    = (frame_width_ff == '0) ? 13'd1 : frame_width_ff;
   assign fh_eff    = (frame_height_ff == '0) ? 13'd1 : frame_height_ff;
   assign py_c      = clamp_hi(py_raw_ff, fh_eff - 1'b1);
   assign py_c_next = clamp_hi(py_raw_ff + 2'sd1, fh_eff - 1'b1);
   assign base_prod = (2*COORD_W)'(py_c) * (2*COORD_W)'(fw_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff <= '0;
         pen_y_ff <= '0;
      end else if (cmd.prep) begin
         if (sts.newline) begin
            pen_x_ff <= '0;
            pen_y_ff <= pen_y_nl[16] ? 16'hFFFF : pen_y_nl[15:0];
         end else begin
            pen_x_ff <= eff_x;
            pen_y_ff <= eff_y;
         end
      end else if (cmd.row_load && cmd.row_last) begin
         pen_x_ff <= pen_x_adv[16] ? 16'hFFFF : pen_x_adv[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         cx_ff     <= glyph_no[CX_W-1:0];
         ry_ff     <= RY_W'(glyph_no[CELL_W-1:CX_W] * GLYPH_H);
         px_raw_ff <= $signed({2'b00, eff_x}) + POS_W'(origin_x_ff) + 2'sd1;
         py_raw_ff <= $signed({2'b00, eff_y}) + POS_W'(origin_y_ff) + 2'sd1;
      end else if (cmd.setup) begin
         py_c_ff <= py_c;
         base_ff <= base_prod[OFF_W-1:0];
         for (int c = 0; c < GLYPH_W; c++) begin
            px_ff[c] <= clamp_hi(px_raw_ff + POS_W'(c), fw_eff - 1'b1);
         end
      end else if (cmd.row_load) begin
         // The clamped row moves by at most one, so the row base steps by the stride.
         ry_ff     <= ry_ff + 1'b1;
         py_raw_ff <= py_raw_ff + 2'sd1;
         py_c_ff   <= py_c_next;
         if (py_c_next != py_c_ff) begin
            base_ff <= base_ff + OFF_W'(fw_eff);
         end
      end
   end

   assign rd_en   = cmd.setup || (cmd.row_load && !cmd.row_last);
   assign rd_addr = cmd.setup ? {ry_ff, cx_ff} : {ry_ff + 1'b1, cx_ff};

   always_ff @(posedge clock) begin
      if (cmd.sheet_write && wr_in_range) begin
         sheet_mem[wr_addr][wr_lane] <= ink_bit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         sheet_q_ff <= sheet_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.row_load) begin
         for (int c = 0; c < GLYPH_W; c++) begin
            offset_ff[c] <= base_ff + OFF_W'(px_ff[c]);
         end
         ink_mask_ff   <= sheet_q_ff;
         write_mask_ff <= sheet_q_ff | {GLYPH_W{opaque_ff}};
         ink_word_ff   <= {8'hFF, text_color_ff};
         last_row_ff   <= cmd.row_last;
      end
   end

   assign offset_0   = offset_ff[0];
   assign offset_1   = offset_ff[1];
   assign offset_2   = offset_ff[2];
   assign offset_3   = offset_ff[3];
   assign offset_4   = offset_ff[4];
   assign offset_5   = offset_ff[5];
   assign write_mask = write_mask_ff;
   assign ink_mask   = ink_mask_ff;
   assign ink_word   = ink_word_ff;
   assign last_row   = last_row_ff;

endmodule

@@ rtl/bitmap_font_text_renderer_unit.sv @@
// Bitmap font text renderer. A load request (func 0) writes one pixel of the
// 192x52 one-bit font sheet if its index lies within the sheet; the next request
// is accepted only once that write is done. A draw request (func 1) with newline
// only moves the pen. Any other character gives thirteen responses, one per glyph
// row: the request is accepted, the pen is set, the first row address and row
// base are formed, then one row per cycle while responses are taken at once,
// bounded by the single read port of the font sheet memory. A stalled response
// holds back the rows behind it, but the next request is accepted while the last
// row still waits in the output register. Configuration writes are always taken
// and must only be issued while the block is idle.
module bitmap_font_text_renderer_unit (
   input  logic       clock,
   input  logic       reset,
   bftr_req_if.sink   req,
   bftr_rsp_if.source rsp,
   bftr_csr_if.sink   csr
);
   import bftr_pkg::*;

   bftr_cmd_type cmd;
   bftr_sts_type sts;

   assign csr.ready = 1'b1;

   bftr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_func  (req.func),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bftr_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_sheet_index   (req.sheet_index),
      .req_sheet_value   (req.sheet_value),
      .req_char_code     (req.char_code),
      .req_start_of_text (req.start_of_text),
      .csr_write         (csr.valid),
      .csr_index         (csr.index),
      .csr_data          (csr.data),
      .offset_0          (rsp.offset_0),
      .offset_1          (rsp.offset_1),
      .offset_2          (rsp.offset_2),
      .offset_3          (rsp.offset_3),
      .offset_4          (rsp.offset_4),
      .offset_5          (rsp.offset_5),
      .write_mask        (rsp.write_mask),
      .ink_mask          (rsp.ink_mask),
      .ink_word          (rsp.ink_word),
      .last_row          (rsp.last_row)
   );

endmodule

@@ rtl/bftr_checker.sv @@
module bftr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [5:0]  write_mask,
   input logic [5:0]  ink_mask,
   input logic [31:0] ink_word
);

   // A response that is not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // An accepted request leaves the block busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted twice in a row");

   // Every ink pixel is also written.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((ink_mask & ~write_mask) == 6'd0))
      else $error("ink column missing from write mask");

   // A new run of rows only starts while a glyph is being drawn.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_ready)
      else $error("response started while idle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (ink_word[31:24] == 8'hFF))
      else $error("ink word alpha not opaque");

endmodule

bind bitmap_font_text_renderer_unit bftr_checker u_bftr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .write_mask (rsp.write_mask),
   .ink_mask   (rsp.ink_mask),
   .ink_word   (rsp.ink_word)
);

@@ dv/tb_bitmap_font_text_renderer_unit.sv @@
module tb_bitmap_font_text_renderer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import bftr_pkg::*;

   localparam int PEN_MAX        = 65535;
   localparam int PUNCT_BASE     = 96;
   localparam int DRAIN_CYCLES   = 24;
   localparam int LONG_STALL     = 200;
   localparam int WATCHDOG_LIMIT = 1500;
   localparam int MAX_REPORTS    = 30;

   localparam logic [BYTE_W-1:0] CHAR_NUL        = 8'd0;
   localparam logic [BYTE_W-1:0] CHAR_SPACE      = 8'd32;
   localparam logic [BYTE_W-1:0] CHAR_DEL        = 8'd127;
   localparam logic [BYTE_W-1:0] CHAR_HIGH_FIRST = 8'd128;
   localparam logic [BYTE_W-1:0] CHAR_MAX        = 8'd255;
   localparam logic [7:0]        ALPHA_OPAQUE    = 8'hFF;

   // Punctuation cells in sheet order; the zero entries are unused cells.
   localparam logic [7:0] PUNCT_CODES [32] = '{
      8'd33, 8'd63, 8'd35, 8'd38, 8'd95, 8'd37, 8'd39, 8'd44,
      8'd46, 8'd59, 8'd58, 8'd94, 8'd124, 8'd0, 8'd0, 8'd96,
      8'd0, 8'd126, 8'd61, 8'd60, 8'd62, 8'd43, 8'd45, 8'd42,
      8'd47, 8'd92, 8'd40, 8'd41, 8'd123, 8'd125, 8'd91, 8'd93};

   typedef struct packed {
      logic              func;
      logic [IDX_W-1:0]  sheet_index;
      logic [BYTE_W-1:0] sheet_value;
      logic [BYTE_W-1:0] char_code;
      logic              start_of_text;
   } text_item_type;

   typedef struct packed {
      logic [5:0][OFF_W-1:0] offs;
      logic [5:0]            wmask;
      logic [5:0]            imask;
      logic [WORD_W-1:0]     ink;
      logic                  last;
   } glyph_row_type;

   logic clock;
   logic reset;

   bftr_req_if req_ch ();
   bftr_rsp_if rsp_ch ();
   bftr_csr_if csr_ch ();

   bitmap_font_text_renderer_unit uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // Shadow of the renderer: font sheet, pen and register contents.
   bit               ink_sheet [SHEET_SIZE];
   int               pen_x = 0;
   int               pen_y = 0;
   int               cfg_ox = 0;
   int               cfg_oy = 0;
   int               cfg_fw = 640;
   int               cfg_fh = 480;
   logic [COLOR_W-1:0] cfg_color = 24'hFFFFFF;
   bit               cfg_opaque = 1'b0;

   text_item_type text_queue [$];
   glyph_row_type due_rows [$];

   text_item_type cur_item;
   bit  idling = 1'b1;
   bit  req_busy = 1'b0;
   bit  req_took = 1'b0;
   bit  rsp_took = 1'b0;
   int  req_gap = 0;
   int  rsp_gap = 0;
   int  hold_left = 0;
   int  long_stalls_asked = 0;
   int  long_stalls_done = 0;
   int  stuck_cycles = 0;

   int  mismatches = 0;
   int  rows_checked = 0;
   int  chars_drawn = 0;
   int  newlines_seen = 0;
   int  loads_seen = 0;
   int  settings_used = 0;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_LOAD;
      req_ch.sheet_index = '0;
      req_ch.sheet_value = '0;
      req_ch.char_code = '0;
      req_ch.start_of_text = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_ORIGIN_X;
      csr_ch.data = '0;
      forever #5 clock = ~clock;
   end

   function automatic int saturate_pen(input int v);
      return (v > PEN_MAX) ? PEN_MAX : v;
   endfunction

   function automatic int clip(input int v, input int hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int cell_of(input logic [BYTE_W-1:0] c);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return int'(c - CHAR_UPPER_A);
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
         return int'(c - CHAR_LOWER_A) + int'(CELL_LOWER);
      if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
         return int'(c - CHAR_DIGIT_0) + int'(CELL_DIGIT);
      if (c == CHAR_DOLLAR) return int'(CELL_DOLLAR);
      if (c == CHAR_NUL || c >= CHAR_HIGH_FIRST) return int'(CELL_BLANK);
      for (int i = 0; i < 32; i++)
         if (PUNCT_CODES[i] == c) return PUNCT_BASE + i;
      return int'(CELL_BLANK);
   endfunction

   task automatic apply_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      case (idx)
         CSR_ORIGIN_X:     cfg_ox = int'($signed(d[11:0]));
         CSR_ORIGIN_Y:     cfg_oy = int'($signed(d[11:0]));
         CSR_FRAME_WIDTH:  cfg_fw = int'(d[12:0]);
         CSR_FRAME_HEIGHT: cfg_fh = int'(d[12:0]);
         CSR_TEXT_COLOR:   cfg_color = d[COLOR_W-1:0];
         CSR_OPAQUE:       cfg_opaque = d[0];
         default: ;
      endcase
   endtask

   // Updates the shadow for one accepted request and works out the glyph rows that it must produce.
   task automatic render_request(input text_item_type r);
      int base, fw, fh, py, px, cell_no;
      bit ink;
      glyph_row_type row_exp;
      if (r.func == FUNC_LOAD) begin
         loads_seen++;
         if (r.sheet_index < SHEET_SIZE) ink_sheet[r.sheet_index] = (r.sheet_value == 0);
         return;
      end
      if (r.start_of_text) begin
         pen_x = 0;
         pen_y = 0;
      end
      if (r.char_code == CHAR_NEWLINE) begin
         newlines_seen++;
         pen_x = 0;
         pen_y = saturate_pen(pen_y + GLYPH_H);
         return;
      end
      chars_drawn++;
      cell_no = cell_of(r.char_code);
      base = (cell_no % SHEET_COLS) * GLYPH_W + (cell_no / SHEET_COLS) * GLYPH_H * SHEET_W;
      fw = (cfg_fw == 0) ? 1 : cfg_fw;
      fh = (cfg_fh == 0) ? 1 : cfg_fh;
      for (int y = 0; y < GLYPH_H; y++) begin
         row_exp = '0;
         py = clip(pen_y + y + cfg_oy + 1, fh - 1);
         for (int x = 0; x < GLYPH_W; x++) begin
            px = clip(pen_x + x + cfg_ox + 1, fw - 1);
            ink = ink_sheet[base + y * SHEET_W + x];
            row_exp.offs[x] = OFF_W'(py * fw + px);
            row_exp.imask[x] = ink;
            row_exp.wmask[x] = ink | cfg_opaque;
         end
         row_exp.ink = {ALPHA_OPAQUE, cfg_color};
         row_exp.last = (y == GLYPH_H - 1);
         due_rows.push_back(row_exp);
      end
      pen_x = saturate_pen(pen_x + GLYPH_W);
   endtask

   task automatic report_field(input string field, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
   endtask

   task automatic compare_row(input glyph_row_type want, input glyph_row_type got);
      for (int k = 0; k < GLYPH_W; k++)
         if (got.offs[k] !== want.offs[k])
            report_field($sformatf("offset_%0d", k), WORD_W'(want.offs[k]),
                         WORD_W'(got.offs[k]));
      if (got.wmask !== want.wmask)
         report_field("write_mask", WORD_W'(want.wmask), WORD_W'(got.wmask));
      if (got.imask !== want.imask)
         report_field("ink_mask", WORD_W'(want.imask), WORD_W'(got.imask));
      if (got.ink !== want.ink) report_field("ink_word", want.ink, got.ink);
      if (got.last !== want.last)
         report_field("last_row", WORD_W'(want.last), WORD_W'(got.last));
   endtask

   // Monitor: responses are checked before the request of the same edge is predicted.
   always @(posedge clock) begin
      glyph_row_type got;
      text_item_type seen;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_took = 1'b1;
            got.offs[0] = rsp_ch.offset_0;
            got.offs[1] = rsp_ch.offset_1;
            got.offs[2] = rsp_ch.offset_2;
            got.offs[3] = rsp_ch.offset_3;
            got.offs[4] = rsp_ch.offset_4;
            got.offs[5] = rsp_ch.offset_5;
            got.wmask = rsp_ch.write_mask;
            got.imask = rsp_ch.ink_mask;
            got.ink = rsp_ch.ink_word;
            got.last = rsp_ch.last_row;
            rows_checked++;
            if (due_rows.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: glyph row with none expected, expected nothing, got offset_0 0x%0h",
                           $time, got.offs[0]);
            end else begin
               compare_row(due_rows.pop_front(), got);
            end
         end
         if (csr_ch.valid && csr_ch.ready) apply_reg(csr_ch.index, csr_ch.data);
         if (req_ch.valid && req_ch.ready) begin
            req_took = 1'b1;
            seen.func = req_ch.func;
            seen.sheet_index = req_ch.sheet_index;
            seen.sheet_value = req_ch.sheet_value;
            seen.char_code = req_ch.char_code;
            seen.start_of_text = req_ch.start_of_text;
            render_request(seen);
         end
      end
   end

   // Request driver.
   always @(negedge clock) begin
      if (req_took) begin
         req_took = 1'b0;
         req_busy = 1'b0;
      end
      if (!req_busy && !reset) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (text_queue.size() != 0) begin
            cur_item = text_queue.pop_front();
            req_busy = 1'b1;
            req_gap = idling ? $urandom_range(0, 4) : 0;
         end
      end
      req_ch.valid <= req_busy;
      req_ch.func <= cur_item.func;
      req_ch.sheet_index <= cur_item.sheet_index;
      req_ch.sheet_value <= cur_item.sheet_value;
      req_ch.char_code <= cur_item.char_code;
      req_ch.start_of_text <= cur_item.start_of_text;
   end

   // Response receiver, with an occasional long hold-off to back the block up.
   always @(negedge clock) begin
      bit ready_next;
      if (rsp_took) begin
         rsp_took = 1'b0;
         rsp_gap = idling ? $urandom_range(0, 4) : 0;
      end
      if (long_stalls_done != long_stalls_asked) begin
         long_stalls_done = long_stalls_asked;
         hold_left = LONG_STALL;
      end
      if (hold_left > 0) begin
         hold_left--;
         ready_next = 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         ready_next = 1'b0;
      end else begin
         ready_next = 1'b1;
      end
      rsp_ch.ready <= ready_next;
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
      end
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: nothing accepted for %0d cycles, %0d glyph rows still awaited",
                  $time, stuck_cycles, due_rows.size());
         $display("FAIL bitmap_font_text_renderer_unit");
         $finish;
      end
   end

   function automatic void push_load(input int idx, input int value);
      text_item_type it;
      it.func = FUNC_LOAD;
      it.sheet_index = IDX_W'(idx);
      it.sheet_value = BYTE_W'(value);
      it.char_code = BYTE_W'($urandom_range(0, 255));
      it.start_of_text = 1'($urandom_range(0, 1));
      text_queue.push_back(it);
   endfunction

   function automatic void push_char(input logic [BYTE_W-1:0] code, input bit sot);
      text_item_type it;
      it.func = FUNC_DRAW;
      it.sheet_index = IDX_W'($urandom_range(0, 16383));
      it.sheet_value = BYTE_W'($urandom_range(0, 255));
      it.char_code = code;
      it.start_of_text = sot;
      text_queue.push_back(it);
   endfunction

   // Loads every pixel of one glyph cell, so that drawing it never reads an unloaded pixel.
   function automatic void push_cell_loads(input int cell_no);
      int base;
      base = (cell_no % SHEET_COLS) * GLYPH_W + (cell_no / SHEET_COLS) * GLYPH_H * SHEET_W;
      for (int y = 0; y < GLYPH_H; y++)
         for (int x = 0; x < GLYPH_W; x++)
            push_load(base + y * SHEET_W + x,
                      ($urandom_range(0, 99) < 35) ? 0 : int'($urandom_range(1, 255)));
   endfunction

   // Only characters whose cells have been loaded are drawn.
   function automatic logic [BYTE_W-1:0] drawable_code();
      int pick;
      pick = $urandom_range(0, 3);
      case (pick)
         0:       return CHAR_UPPER_A;
         1:       return PUNCT_CODES[31];
         2:       return BYTE_W'($urandom_range(CHAR_HIGH_FIRST, CHAR_MAX));
         default: return CHAR_SPACE;
      endcase
   endfunction

   function automatic void push_random_item();
      int pick;
      bit sot;
      pick = $urandom_range(0, 99);
      sot = ($urandom_range(0, 9) == 0);
      if (pick < 12) begin
         push_load(($urandom_range(0, 3) == 0) ? int'($urandom_range(SHEET_SIZE, 16383))
                                               : int'($urandom_range(0, SHEET_SIZE - 1)),
                   ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 255)));
      end else if (pick < 25) begin
         push_char(CHAR_NEWLINE, sot);
      end else begin
         push_char(drawable_code(), sot);
      end
   endfunction

   // Waits until the block has nothing left in flight.
   task automatic settle();
      while (text_queue.size() != 0 || req_busy || due_rows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= CSR_DATA_W'(value);
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic load_setting(input int ox, input int oy, input int fw, input int fh,
                               input int color, input bit opq);
      settle();
      write_reg(CSR_ORIGIN_X, ox & 12'hFFF);
      write_reg(CSR_ORIGIN_Y, oy & 12'hFFF);
      write_reg(CSR_FRAME_WIDTH, fw);
      write_reg(CSR_FRAME_HEIGHT, fh);
      write_reg(CSR_TEXT_COLOR, color);
      write_reg(CSR_OPAQUE, int'(opq));
      settings_used++;
   endtask

   task automatic random_setting();
      int ox, oy, fw, fh;
      ox = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 4095)) - 2048
                                       : int'($urandom_range(0, 100)) - 50;
      oy = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 4095)) - 2048
                                       : int'($urandom_range(0, 100)) - 50;
      fw = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 160) : $urandom_range(1, 4096);
      fh = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 120) : $urandom_range(1, 4096);
      load_setting(ox, oy, fw, fh, int'($urandom_range(0, 24'hFFFFFF)),
                   1'($urandom_range(0, 1)));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The cells that are drawn are loaded in full first: a capital letter, the blank
      // cell that every unknown code falls back to, and the cell that ends the sheet.
      idling = 1'b0;
      push_cell_loads(cell_of(CHAR_UPPER_A));
      push_cell_loads(int'(CELL_BLANK));
      push_cell_loads(cell_of(PUNCT_CODES[31]));

      load_setting(10, 5, 640, 480, 24'h123456, 1'b0);
      idling = 1'b1;
      push_load(16383, 0);
      push_load(SHEET_SIZE, 0);
      push_char(CHAR_UPPER_A, 1'b1);
      push_char(CHAR_NUL, 1'b0);
      push_char(CHAR_SPACE, 1'b0);
      push_char(CHAR_DEL, 1'b0);
      push_char(CHAR_NEWLINE, 1'b0);
      push_char(CHAR_HIGH_FIRST, 1'b0);
      push_char(CHAR_MAX, 1'b0);
      push_char(CHAR_NEWLINE, 1'b1);
      // The last row of the final cell ends on the last pixel of the sheet.
      push_load(SHEET_SIZE - 1, 255);
      push_char(PUNCT_CODES[31], 1'b0);
      push_load(SHEET_SIZE - 1, 0);
      push_char(PUNCT_CODES[31], 1'b0);
      settle();

      // Receiver holds off while the sender keeps offering requests back to back.
      idling = 1'b0;
      long_stalls_asked++;
      for (int i = 0; i < 5; i++) push_char(drawable_code(), 1'b0);
      settle();
      idling = 1'b1;

      load_setting(-2048, -2048, 1, 1, 0, 1'b1);
      for (int i = 0; i < 2; i++) push_random_item();
      load_setting(2047, 2047, 4096, 4096, 24'hFFFFFF, 1'b0);
      for (int i = 0; i < 2; i++) push_random_item();
      load_setting(-7, 3, 0, 0, 24'hA5C3E1, 1'b1);
      for (int i = 0; i < 2; i++) push_random_item();
      load_setting(100, 1000, 8191, 8191, 24'h5A3C1E, 1'b0);
      for (int i = 0; i < 2; i++) push_random_item();

      for (int s = 0; s < 2; s++) begin
         random_setting();
         for (int i = 0; i < 2; i++) push_random_item();
      end

      settle();
      $display("Checked %0d glyph rows from %0d characters, with %0d newlines, %0d sheet loads",
               rows_checked, chars_drawn, newlines_seen, loads_seen);
      $display("and %0d register settings, including clamped origins and degenerate frames.",
               settings_used);
      if (mismatches == 0) begin
         $display("PASS bitmap_font_text_renderer_unit");
      end else begin
         $display("FAIL bitmap_font_text_renderer_unit");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/bftr_pkg.sv
rtl/bftr_if.sv
rtl/bftr_ctrl.sv
rtl/bftr_dp.sv
rtl/bitmap_font_text_renderer_unit.sv
rtl/bftr_checker.sv
dv/tb_bitmap_font_text_renderer_unit.sv
